[hdl/tswi_pkg.sv]
// Package for the two-source wave interference pixel generator.
// Holds register indexes, reset values, field widths and the config struct.
// No dependencies.
package tswi_pkg;

  localparam int DefWidth  = 600;
  localparam int DefHeight = 600;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_AMP_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AMP_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FREQ_A  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FREQ_B  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PHASE_A = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PHASE_B = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OFFSET  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TSTEP   = 3'd7;

  localparam logic [11:0] AMP_RST   = 12'd480;
  localparam logic [15:0] FREQ_RST  = 16'd1252;
  localparam logic [9:0]  OFFSET_RST = 10'd180;
  localparam logic [15:0] TSTEP_RST = 16'd2086;

  // square root: 54-bit radicand gives 27-bit root (27 steps of one bit)
  localparam int SqW   = 54;
  localparam int RootW = 27;

  typedef struct packed {
    logic [11:0] amp;
    logic [15:0] freq;
    logic [15:0] phase;
  } src_cfg_t;

endpackage

[hdl/tswi_if.sv]
// Valid/ready channel interfaces for the pixel generator.
// Depends on tswi_pkg for the configuration widths.
interface tswi_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  modport source (output valid, frame_start, pixel_x, pixel_y, input ready);
  modport sink   (input valid, frame_start, pixel_x, pixel_y, output ready);
endinterface

interface tswi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface tswi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tswi_pkg::CfgIdxW-1:0]  index;
  logic [tswi_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tswi_wave.sv]
// One source's wave: distance, bit-per-stage square root, phase, sine, amplitude.
// Depends on tswi_pkg. Fully registered pipeline; advances only on en.
module tswi_wave #(
  parameter int WIDTH  = tswi_pkg::DefWidth,
  parameter int HEIGHT = tswi_pkg::DefHeight
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [9:0]              pixel_x,
  input  logic [9:0]              pixel_y,
  input  logic signed [13:0]      src_x,
  input  logic [15:0]             time_phase,
  input  tswi_pkg::src_cfg_t      cfg,
  output logic signed [30:0]      wave
);
  localparam int SqW   = tswi_pkg::SqW;
  localparam int RootW = tswi_pkg::RootW;
  localparam logic signed [13:0] CenterY = 14'(HEIGHT / 2);

  // stage 0: differences
  logic signed [14:0] dx_r, dy_r;
  logic [15:0] phs0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= $signed({5'd0, pixel_x}) - 15'(src_x);
      dy_r   <= $signed({5'd0, pixel_y}) - 15'(CenterY);
      phs0_r <= cfg.phase - time_phase;
    end
  end

  // stage 1: squares
  logic [29:0] sx_r, sy_r;
  logic [15:0] phs1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= 30'(dx_r * dx_r);
      sy_r   <= 30'(dy_r * dy_r);
      phs1_r <= phs0_r;
    end
  end

  // stage 2: radicand, enters the root pipeline at index 0
  logic [SqW-1:0]   rem_r [RootW+1];
  logic [RootW-1:0] root_r [RootW+1];
  logic [15:0]      phs_r [RootW+1];
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {SqW'({1'b0, sx_r} + {1'b0, sy_r})} << 8;
      root_r[0] <= '0;
      phs_r[0]  <= phs1_r;
    end
  end

  // square root: one result bit per stage (restoring)
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int Sh = 2 * (RootW - 1 - k);
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_hi;
    assign rem_hi = {2'b0, rem_r[k]} >> Sh;
    assign trial  = {root_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_hi >= trial) begin
          rem_r[k+1]  <= rem_r[k] - SqW'(trial << Sh);
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b0};
        end
        phs_r[k+1] <= phs_r[k];
      end
    end
  end

  // angle
  logic [42:0] rf_r;
  logic [15:0] phsa_r, ang_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rf_r   <= root_r[RootW] * cfg.freq;
      phsa_r <= phs_r[RootW];
      ang_r  <= 16'(rf_r >> 4) + phsa_r;
    end
  end

  // sine polynomial
  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [14:0] z1_r, z2z_r, z3_r;
  logic [14:0] zz_r;
  logic [14:0] y1_r, y2_r;
  logic [14:0] t1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r  <= ang_r[15:14];
      z1_r  <= ang_r[14] ? 15'(15'd16384 - {1'b0, ang_r[13:0]}) : {1'b0, ang_r[13:0]};
      zz_r  <= 15'(({14'd0, z1_r} * {14'd0, z1_r}) >> 14);
      q2_r  <= q1_r;
      z2z_r <= z1_r;
      y1_r  <= 15'(15'd10512 - 15'(({10'd0, zz_r} * 25'd1160) >> 14));
      t1_r  <= zz_r;
      q3_r  <= q2_r;
      z3_r  <= z2z_r;
    end
  end
  logic [14:0] z4_r;
  logic [14:0] m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      y2_r <= 15'(15'd25736 - 15'(({13'd0, t1_r} * {13'd0, y1_r}) >> 14));
      z4_r <= z3_r;
      q4_r <= q3_r;
      m_r  <= 15'(({14'd0, z4_r} * {14'd0, y2_r}) >> 14);
    end
  end
  // quadrant travels alongside m
  logic [1:0] qm_r;
  always_ff @(posedge clk) begin
    if (en) qm_r <= q4_r;
  end

  logic [26:0] prod_r;
  logic        sgn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 27'(m_r * cfg.amp);
      sgn_r  <= qm_r[1];
      wave   <= sgn_r ? -$signed({4'd0, prod_r}) : $signed({4'd0, prod_r});
    end
  end
endmodule

[hdl/two_source_wave_interference_pixel_top.sv]
// Two-source wave interference pixel generator, top level.
// Fully pipelined: throughput one pixel per cycle while the output is not stalled.
// Depth is set by the 27-stage one-bit-per-stage square root in each wave unit.
// Stalls freeze the whole pipeline; output register holds the result.
// Reset (rst_n synchronous low) restores register defaults, time phase 0, clears valids.
module two_source_wave_interference_pixel_top #(
  parameter int WIDTH  = tswi_pkg::DefWidth,
  parameter int HEIGHT = tswi_pkg::DefHeight
) (
  input logic      clk,
  input logic      rst_n,
  tswi_in_if.sink  in_ch,
  tswi_out_if.source out_ch,
  tswi_cfg_if.sink cfg_ch
);
  localparam int Lat = 3 + tswi_pkg::RootW + 9;  // wave units
  localparam int Tot = Lat + 2;                  // sum + color

  tswi_pkg::src_cfg_t cfg_a_r, cfg_b_r;
  logic [9:0]  offset_r;
  logic [15:0] tstep_r, tphase_r, tphase_nxt;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r  <= '{amp: tswi_pkg::AMP_RST, freq: tswi_pkg::FREQ_RST, phase: '0};
      cfg_b_r  <= '{amp: tswi_pkg::AMP_RST, freq: tswi_pkg::FREQ_RST, phase: '0};
      offset_r <= tswi_pkg::OFFSET_RST;
      tstep_r  <= tswi_pkg::TSTEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tswi_pkg::REG_AMP_A:   cfg_a_r.amp   <= cfg_ch.data[11:0];
        tswi_pkg::REG_AMP_B:   cfg_b_r.amp   <= cfg_ch.data[11:0];
        tswi_pkg::REG_FREQ_A:  cfg_a_r.freq  <= cfg_ch.data;
        tswi_pkg::REG_FREQ_B:  cfg_b_r.freq  <= cfg_ch.data;
        tswi_pkg::REG_PHASE_A: cfg_a_r.phase <= cfg_ch.data;
        tswi_pkg::REG_PHASE_B: cfg_b_r.phase <= cfg_ch.data;
        tswi_pkg::REG_OFFSET:  offset_r      <= cfg_ch.data[9:0];
        tswi_pkg::REG_TSTEP:   tstep_r       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic en, in_acc;
  logic [Tot-1:0] vld_r;
  assign en = !vld_r[Tot-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc = in_ch.valid && en;

  assign tphase_nxt = in_ch.frame_start ? tphase_r + tstep_r : tphase_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tphase_r <= '0;
    else if (in_acc) tphase_r <= tphase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Tot-2:0], in_ch.valid};
  end

  logic signed [13:0] sxa, sxb;
  assign sxa = $signed({4'd0, offset_r});
  assign sxb = 14'(WIDTH) - $signed({4'd0, offset_r});

  logic signed [30:0] wa, wb;
  tswi_wave #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_wave_a (
    .clk, .en, .pixel_x(in_ch.pixel_x), .pixel_y(in_ch.pixel_y),
    .src_x(sxa), .time_phase(tphase_nxt), .cfg(cfg_a_r), .wave(wa));
  tswi_wave #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_wave_b (
    .clk, .en, .pixel_x(in_ch.pixel_x), .pixel_y(in_ch.pixel_y),
    .src_x(sxb), .time_phase(tphase_nxt), .cfg(cfg_b_r), .wave(wb));

  logic signed [31:0] sum_r;
  logic [33:0] mag;
  logic [35:0] p5, p3;
  logic [7:0] red_r, green_r, blue_r;
  always_ff @(posedge clk) begin
    if (en) sum_r <= 32'(wa) + 32'(wb);
  end
  assign mag = sum_r[31] ? 34'(-sum_r) : 34'(sum_r);
  assign p5  = 36'(mag) * 36'd5;
  assign p3  = 36'(mag) * 36'd3;
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_r > 0) begin
        red_r   <= '0;
        green_r <= (p3[35:20] > 16'd255) ? 8'd255 : p3[27:20];
        blue_r  <= (p5[35:18] > 18'd255) ? 8'd255 : p5[25:18];
      end else begin
        red_r   <= (p5[35:18] > 18'd255) ? 8'd255 : p5[25:18];
        green_r <= '0;
        blue_r  <= '0;
      end
    end
  end

  assign out_ch.valid = vld_r[Tot-1];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.red))
    else $error("result changed under stall");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.red == 8'd0) || (out_ch.green == 8'd0 && out_ch.blue == 8'd0))
    else $error("red and green/blue both driven");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(tphase_r))
    else $error("time phase moved without a transaction");
endmodule
